[sv/ed_pkg.sv]
// ----------------------------------------------------------------------------
// ed_pkg
// shared types and constants of the edit distance engine
// ----------------------------------------------------------------------------
package ed_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int OP_W        = 2;
  localparam int CHAR_W      = 8;
  localparam int DIST_W      = 7;
  localparam int DIST_CAP    = 127;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND_A = 2'd0,
    OP_APPEND_B = 2'd1,
    OP_COMPUTE  = 2'd2
  } ed_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW,
    ST_RD,
    ST_WR,
    ST_FIN_RD,
    ST_FIN_WAIT
  } ed_state_t;

  // datapath commands, one strobe per sequencer step
  typedef struct packed {
    logic take;
    logic init;
    logic row;
    logic rd;
    logic wr;
    logic fin_rd;
    logic load;
  } ed_cmd_t;

  typedef struct packed {
    logic col_last;
    logic row_last;
    logic a_empty;
    logic b_empty;
  } ed_sts_t;

endpackage

[sv/ed_if.sv]
// ----------------------------------------------------------------------------
// ed_in_if / ed_out_if
// valid/ready channels of the edit distance engine
// ----------------------------------------------------------------------------
interface ed_in_if;
  import ed_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, output opcode, output char_in, input ready);
  modport sink   (input valid, input opcode, input char_in, output ready);
endinterface

interface ed_out_if;
  import ed_pkg::*;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              overflowed;

  modport source (output valid, output distance, output overflowed, input ready);
  modport sink   (input valid, input distance, input overflowed, output ready);
endinterface

[sv/ed_ctrl.sv]
// ----------------------------------------------------------------------------
// ed_ctrl
// sequencer that walks the cost table one cell at a time
// ----------------------------------------------------------------------------
module ed_ctrl
  import ed_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OP_W-1:0] in_opcode,
  output logic            out_valid,
  input  logic            out_ready,
  input  ed_sts_t         sts,
  output ed_cmd_t         cmd
);

  ed_state_t state_r, state_nxt;
  logic      out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_opcode == OP_COMPUTE) state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init = 1'b1;
        if (sts.col_last) state_nxt = sts.a_empty ? ST_FIN_RD : ST_ROW;
      end
      ST_ROW: begin
        cmd.row = 1'b1;
        if (sts.b_empty) state_nxt = sts.row_last ? ST_FIN_RD : ST_ROW;
        else             state_nxt = ST_RD;
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        cmd.wr = 1'b1;
        if (sts.col_last) state_nxt = sts.row_last ? ST_FIN_RD : ST_ROW;
        else              state_nxt = ST_RD;
      end
      ST_FIN_RD: begin
        cmd.fin_rd = 1'b1;
        state_nxt  = ST_FIN_WAIT;
      end
      ST_FIN_WAIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WR |-> $past(state_r) == ST_RD)
    else $error("cell write without a preceding read");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN_WAIT)
    else $error("result raised outside the final step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN_WAIT && out_valid_r && !out_ready) |=> state_r == ST_FIN_WAIT)
    else $error("pending result overwritten");

endmodule

[sv/ed_dp.sv]
// ----------------------------------------------------------------------------
// ed_dp
// string stores, cost row memory and the cell update
// ----------------------------------------------------------------------------
module ed_dp
  import ed_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ed_cmd_t           cmd,
  input  logic [OP_W-1:0]   opcode,
  input  logic [CHAR_W-1:0] char_in,
  output ed_sts_t           sts,
  output logic [DIST_W-1:0] distance,
  output logic              overflowed
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [CHAR_W-1:0] mem_a [MAX_LEN];
  logic [CHAR_W-1:0] mem_b [MAX_LEN];
  logic [CW-1:0]     mem_c [MAX_LEN+1];

  logic [CHAR_W-1:0] rd_a_r, rd_b_r;
  logic [CW-1:0]     rd_c_r;
  logic [CW-1:0]     cnt_a_r, cnt_b_r;
  logic              ovf_r;
  logic [CW-1:0]     row_r, col_r;
  logic [CW-1:0]     diag_r, left_r;
  logic [DIST_W-1:0] dist_r;
  logic              ovf_out_r;

  logic          app_a, app_b, full_a, full_b;
  logic [CW-1:0] row_m1, col_m1, lo_w, new_w;
  logic          c_we;
  logic [CW-1:0] c_wa, c_wd;

  assign full_a = (cnt_a_r == CW'(MAX_LEN));
  assign full_b = (cnt_b_r == CW'(MAX_LEN));
  assign app_a  = cmd.take && (opcode == OP_APPEND_A);
  assign app_b  = cmd.take && (opcode == OP_APPEND_B);
  assign row_m1 = row_r - CW'(1);
  assign col_m1 = col_r - CW'(1);

  // cell update: diagonal on a match, else one plus the smallest neighbor
  always_comb begin
    lo_w = left_r;
    if (rd_c_r < lo_w) lo_w = rd_c_r;
    if (diag_r < lo_w) lo_w = diag_r;
    new_w = (rd_a_r == rd_b_r) ? diag_r : lo_w + CW'(1);
  end

  always_comb begin
    c_we = 1'b0;
    c_wa = col_r;
    c_wd = new_w;
    if (cmd.init) begin
      c_we = 1'b1;
      c_wd = col_r;
    end else if (cmd.row) begin
      c_we = 1'b1;
      c_wa = '0;
      c_wd = row_r;
    end else if (cmd.wr) begin
      c_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (app_a && !full_a) mem_a[cnt_a_r[AW-1:0]] <= char_in;
    if (cmd.row) rd_a_r <= mem_a[row_m1[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (app_b && !full_b) mem_b[cnt_b_r[AW-1:0]] <= char_in;
    if (cmd.rd) rd_b_r <= mem_b[col_m1[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (c_we) mem_c[c_wa] <= c_wd;
    if (cmd.rd)          rd_c_r <= mem_c[col_r];
    else if (cmd.fin_rd) rd_c_r <= mem_c[cnt_b_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.load) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (app_a) begin
        if (full_a) ovf_r <= 1'b1;
        else        cnt_a_r <= cnt_a_r + CW'(1);
      end
      if (app_b) begin
        if (full_b) ovf_r <= 1'b1;
        else        cnt_b_r <= cnt_b_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) col_r <= '0;
    else if (cmd.init || cmd.wr) col_r <= col_r + CW'(1);
    else if (cmd.row) col_r <= CW'(1);

    if (cmd.init) row_r <= CW'(1);
    else if ((cmd.row && sts.b_empty) || (cmd.wr && sts.col_last)) row_r <= row_r + CW'(1);

    if (cmd.row) begin
      diag_r <= row_m1;
      left_r <= row_r;
    end else if (cmd.wr) begin
      diag_r <= rd_c_r;
      left_r <= new_w;
    end

    if (cmd.load) begin
      if (32'(rd_c_r) > 32'(DIST_CAP)) dist_r <= DIST_W'(DIST_CAP);
      else                             dist_r <= DIST_W'(rd_c_r);
      ovf_out_r <= ovf_r;
    end
  end

  assign sts.col_last = (col_r == cnt_b_r);
  assign sts.row_last = (row_r == cnt_a_r);
  assign sts.a_empty  = (cnt_a_r == '0);
  assign sts.b_empty  = (cnt_b_r == '0);

  assign distance   = dist_r;
  assign overflowed = ovf_out_r;

  a_clear_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (cnt_a_r == '0 && cnt_b_r == '0 && !ovf_r))
    else $error("strings not cleared after result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_a_r <= CW'(MAX_LEN) && cnt_b_r <= CW'(MAX_LEN))
    else $error("string count past capacity");

endmodule

[sv/edit_distance_engine.sv]
// ----------------------------------------------------------------------------
// edit_distance_engine
// unit-cost levenshtein distance between two byte strings
// ----------------------------------------------------------------------------
// Items on in_chan append a byte to the first string (opcode 0), to the
// second string (opcode 1), or compute (opcode 2); opcode 3 is taken and
// ignored. A byte sent to a string that already holds MAX_LEN bytes is
// dropped and sets the overflowed flag of the next result. A compute
// transaction fills the cost row with 0..n, n being the second string's
// length, then walks the table row by row: a row step loads the first
// string's byte and the left column, and each cell has a read step for
// the up cost and the second string's byte, then an update and write-back
// step, and a final read step fetches the final cost. The sequencer's
// separate read and write step for each cell sets the pace of a compute.
// The input is not ready during a compute. One result per compute, held in
// an output register, so appends go on while a result waits; the distance
// saturates at 127 and both strings and the flag clear afterwards.
// ----------------------------------------------------------------------------
module edit_distance_engine
  import ed_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input logic      clk,
  input logic      rst_n,
  ed_in_if.sink    in_chan,
  ed_out_if.source out_chan
);

  ed_cmd_t cmd;
  ed_sts_t sts;

  // sequencer: owns handshakes and the table walk order
  ed_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_opcode (in_chan.opcode),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: text stores, cost row and the result register
  ed_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .opcode     (in_chan.opcode),
    .char_in    (in_chan.char_in),
    .sts        (sts),
    .distance   (out_chan.distance),
    .overflowed (out_chan.overflowed)
  );

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the edit distance engine
// ----------------------------------------------------------------------------
// A queue of append/compute transactions is built up front: a short directed
// list (empty strings, unused opcode, byte extremes, string overflow on either
// side) followed by random string pairs, most of them short, some medium and
// a handful near or past the string capacity. The pairs use full-range bytes,
// a narrow alphabet or a mutated copy of the first string so that matches and
// near-matches are common. A clocked driver feeds the input channel with
// random gaps. The accepted transactions update a local copy of both strings,
// and each compute predicts the distance with a row-by-row cost table. A
// clocked monitor checks each result against the oldest prediction, while
// the receiver stalls at random and once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  import ed_pkg::*;

  localparam int TB_MAX_LEN  = MAX_LEN_DEF;
  localparam int ITEM_TARGET = 1750;   // appends and computes, noise excluded
  localparam int HOLD_AT     = 400;    // transactions taken before the long stall
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int BIG_PAIRS   = 6;      // pairs near or past full capacity

  // opcode 3 has no enum member; the block takes it and does nothing
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
  } op_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflowed;
  } dist_result_t;

  typedef logic [CHAR_W-1:0] text_q_t[$];

  logic clk = 1'b0;
  logic rst_n;

  ed_in_if  in_if();
  ed_out_if out_if();

  edit_distance_engine #(
    .MAX_LEN(TB_MAX_LEN)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if.sink),
    .out_chan(out_if.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // stimulus store and predicted results
  // --------------------------------------------------------------------------
  op_item_t     pending_ops[$];
  dist_result_t expected_results[$];
  int           real_items;     // appends and computes queued so far
  int           big_left;

  // local copy of the engine's strings
  logic [CHAR_W-1:0] first_text  [TB_MAX_LEN];
  logic [CHAR_W-1:0] second_text [TB_MAX_LEN];
  int                first_len;
  int                second_len;
  logic              dropped;

  // run statistics
  int computes_done;
  int overflow_results;
  int max_cells;
  int mismatches;
  int items_taken;    // cleared at start, then written with nonblocking assignments only
  int results_taken;  // same

  // unit-cost levenshtein distance of the two stored strings, one cost row
  function automatic logic [DIST_W-1:0] levenshtein();
    int row [TB_MAX_LEN+1];
    int diag;
    int up;
    int best;
    for (int j = 0; j <= second_len; j++) row[j] = j;
    for (int i = 1; i <= first_len; i++) begin
      diag   = row[0];
      row[0] = i;
      for (int j = 1; j <= second_len; j++) begin
        up = row[j];
        if (first_text[i-1] == second_text[j-1]) begin
          row[j] = diag;
        end else begin
          best = row[j-1] < up ? row[j-1] : up;
          best = best < diag ? best : diag;
          row[j] = best + 1;
        end
        diag = up;
      end
    end
    best = row[second_len];
    if (best > DIST_CAP) best = DIST_CAP;
    return best[DIST_W-1:0];
  endfunction

  // update the local strings for one accepted transaction
  task automatic apply_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch);
    dist_result_t res;
    case (op)
      OP_APPEND_A: begin
        // a full string drops the byte and flags it in the next result
        if (first_len < TB_MAX_LEN) begin
          first_text[first_len] = ch;
          first_len++;
        end else begin
          dropped = 1'b1;
        end
      end
      OP_APPEND_B: begin
        if (second_len < TB_MAX_LEN) begin
          second_text[second_len] = ch;
          second_len++;
        end else begin
          dropped = 1'b1;
        end
      end
      OP_COMPUTE: begin
        res.distance   = levenshtein();
        res.overflowed = dropped;
        expected_results.push_back(res);
        computes_done++;
        if (dropped) overflow_results++;
        if (first_len * second_len > max_cells) max_cells = first_len * second_len;
        first_len  = 0;
        second_len = 0;
        dropped    = 1'b0;
      end
      default: ;  // unused opcode leaves everything alone
    endcase
  endtask

  // --------------------------------------------------------------------------
  // stimulus builders
  // --------------------------------------------------------------------------
  task automatic push_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch);
    op_item_t it;
    it.op = op;
    it.ch = ch;
    pending_ops.push_back(it);
    if (op != OP_UNUSED) real_items++;
  endtask

  // interleave the appends of both strings at random, with unused opcodes as noise if asked, then compute
  task automatic push_pair(input text_q_t a, input text_q_t b, input bit noisy);
    int ia;
    int ib;
    ia = 0;
    ib = 0;
    while (ia < a.size() || ib < b.size()) begin
      if (noisy && $urandom_range(0, 19) == 0)
        push_item(OP_UNUSED, 8'($urandom_range(0, 255)));
      if (ib >= b.size() || (ia < a.size() && $urandom_range(0, 1) == 0)) begin
        push_item(OP_APPEND_A, a[ia]);
        ia++;
      end else begin
        push_item(OP_APPEND_B, b[ib]);
        ib++;
      end
    end
    push_item(OP_COMPUTE, 8'($urandom_range(0, 255)));
  endtask

  // a few random substitutions, insertions and deletions
  function automatic text_q_t mutate(input text_q_t src, input int edits,
                                     input logic [CHAR_W-1:0] base);
    text_q_t dst;
    int pos;
    dst = src;
    repeat (edits) begin
      pos = $urandom_range(0, dst.size());
      case ($urandom_range(0, 2))
        0: dst.insert(pos, base + 8'($urandom_range(0, 3)));
        1: if (pos < dst.size()) dst.delete(pos);
        default: if (pos < dst.size()) dst[pos] = dst[pos] + 8'd1;
      endcase
    end
    return dst;
  endfunction

  task automatic push_random_pair();
    text_q_t a;
    text_q_t b;
    int la;
    int lb;
    int r;
    int style;
    logic [CHAR_W-1:0] base;
    r = $urandom_range(0, 99);
    if (r < 5 && big_left > 0) begin
      // near or past capacity, so overflow shows up here too
      la = $urandom_range(56, 70);
      lb = $urandom_range(56, 70);
      big_left--;
    end else if (r < 15) begin
      la = $urandom_range(9, 24);
      lb = $urandom_range(9, 24);
    end else begin
      la = $urandom_range(0, 8);
      lb = $urandom_range(0, 8);
    end
    style = $urandom_range(0, 2);
    base  = 8'($urandom_range(0, 255));
    for (int k = 0; k < la; k++)
      a.push_back(style == 0 ? 8'($urandom_range(0, 255)) : base + 8'($urandom_range(0, 2)));
    if (style == 2) begin
      b = mutate(a, $urandom_range(0, 3), base);
    end else begin
      for (int k = 0; k < lb; k++)
        b.push_back(style == 0 ? 8'($urandom_range(0, 255)) : base + 8'($urandom_range(0, 2)));
    end
    push_pair(a, b, 1'b1);
  endtask

  // every fourth block of 150 transactions runs without idling
  function automatic int draw_gap(input int count);
    if ((count / 150) % 4 == 3) return 0;
    return $urandom_range(0, 4);
  endfunction

  // --------------------------------------------------------------------------
  // driver: presents queued transactions on the input channel
  // --------------------------------------------------------------------------
  int  in_wait;
  bit  in_take;
  op_item_t next_op;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.opcode  <= '0;
      in_if.char_in <= '0;
      in_wait       = 0;
    end else begin
      in_take = in_if.valid && in_if.ready;
      if (in_take) begin
        apply_item(in_if.opcode, in_if.char_in);
        items_taken <= items_taken + 1;
        in_wait = draw_gap(items_taken);
      end
      // channel is free when nothing is offered or the offer was just taken
      if (in_take || !in_if.valid) begin
        if (in_wait > 0) begin
          in_wait--;
          in_if.valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          next_op = pending_ops.pop_front();
          in_if.valid   <= 1'b1;
          in_if.opcode  <= next_op.op;
          in_if.char_in <= next_op.ch;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // long receiver hold-off: once enough transactions are in, the result
  // channel is blocked so the engine fills up and stalls its input
  // --------------------------------------------------------------------------
  int hold_left;
  bit hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && items_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random ready stalls per result
  // --------------------------------------------------------------------------
  int out_wait;
  bit out_take;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_wait     = 0;
    end else begin
      out_take = out_if.valid && out_if.ready;
      if (out_take) out_wait = draw_gap(results_taken * 7);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
      end else if (out_take || !out_if.ready) begin
        if (out_wait > 0) begin
          out_wait--;
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: each result transaction against the oldest prediction
  // --------------------------------------------------------------------------
  dist_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      results_taken <= results_taken + 1;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: distance %0d overflowed %0b",
               out_if.distance, out_if.overflowed);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_if.distance !== want.distance) begin
          $error("distance mismatch: expected %0d, actual %0d",
                 want.distance, out_if.distance);
          mismatches++;
        end
        if (out_if.overflowed !== want.overflowed) begin
          $error("overflowed mismatch: expected %0b, actual %0b",
                 want.overflowed, out_if.overflowed);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    text_q_t a;
    text_q_t b;

    in_if.valid    = 1'b0;
    in_if.opcode   = '0;
    in_if.char_in  = '0;
    out_if.ready   = 1'b0;
    rst_n          = 1'b0;
    first_len      = 0;
    second_len     = 0;
    dropped        = 1'b0;
    real_items     = 0;
    big_left       = BIG_PAIRS;
    computes_done  = 0;
    overflow_results = 0;
    max_cells      = 0;
    mismatches     = 0;
    items_taken    = 0;
    results_taken  = 0;

    // both strings empty
    push_item(OP_COMPUTE, 8'hFF);
    // unused opcode with both byte patterns, then still empty
    push_item(OP_UNUSED, 8'hAA);
    push_item(OP_UNUSED, 8'h55);
    push_item(OP_COMPUTE, 8'h00);
    // second string empty
    push_item(OP_APPEND_A, 8'h00);
    push_item(OP_COMPUTE, 8'h00);
    // first string empty
    push_item(OP_APPEND_B, 8'hFF);
    push_item(OP_APPEND_B, 8'h80);
    push_item(OP_COMPUTE, 8'h7F);
    // identical byte extremes give zero
    push_item(OP_APPEND_A, 8'h00);
    push_item(OP_APPEND_A, 8'hFF);
    push_item(OP_APPEND_B, 8'h00);
    push_item(OP_APPEND_B, 8'hFF);
    push_item(OP_COMPUTE, 8'h00);
    // swapped pair
    a = '{8'h61, 8'h62};
    b = '{8'h62, 8'h61};
    push_pair(a, b, 1'b0);
    // first string overfilled by one byte
    a.delete();
    b.delete();
    for (int k = 0; k <= TB_MAX_LEN; k++) a.push_back(8'($urandom_range(0, 255)));
    b.push_back(a[0]);
    push_pair(a, b, 1'b0);
    // second string overfilled against an empty first: largest distance
    a.delete();
    b.delete();
    for (int k = 0; k <= TB_MAX_LEN; k++) b.push_back(8'($urandom_range(0, 255)));
    push_pair(a, b, 1'b0);

    while (real_items < ITEM_TARGET) push_random_pair();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // drain: everything offered and taken, every result back
    while (pending_ops.size() > 0 || in_if.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d transactions, %0d distances checked, %0d with overflow",
             items_taken, computes_done, overflow_results);
    $display("largest table %0d cells, long result stall of %0d cycles",
             max_cells, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #8_000_000;
    $display("timeout waiting for the engine");
    $display("== FAIL ==");
    $finish;
  end

endmodule
